FILE: rtl/core/pdvc_pkg.sv
package pdvc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_ITER_DEF = 20;

	localparam logic [34:0] Q30_PI = 35'd3373259426;
	localparam logic [34:0] Q30_HALF_PI = 35'd1686629713;
	localparam logic [34:0] Q30_TWO_PI = 35'd6746518852;
	localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
	localparam logic signed [35:0] Q30_GAIN_INV = 36'sd652032874;
	localparam logic [30:0] SPEED_MAX = 31'h7fffffff;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_DT = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic MODEL_DIFF = 1'b0;

	typedef struct packed {
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [31:0] cur_heading;
		logic signed [31:0] next_x;
		logic signed [31:0] next_y;
		logic signed [31:0] next_heading;
		logic [30:0]        time_step;
	} pose_in_t;

	typedef struct packed {
		logic [30:0]        linear_speed;
		logic signed [31:0] turn_command;
		logic [1:0]         status;
	} cmd_out_t;

	function automatic logic signed [35:0] atan_q30(input int i);
		logic signed [35:0] r;
		case (i)
			0: r = 36'sd843314857;
			1: r = 36'sd497837830;
			2: r = 36'sd263043837;
			3: r = 36'sd133525159;
			4: r = 36'sd67021687;
			5: r = 36'sd33543516;
			6: r = 36'sd16775851;
			7: r = 36'sd8388437;
			8: r = 36'sd4194283;
			9: r = 36'sd2097149;
			default: r = (i < 31) ? (36'sd1 <<< (30 - i)) : 36'sd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/pose_delta_velocity_command.sv
// channel  | dir | payload    | handshake
// pose     | in  | pose_in_t  | pose_valid / pose_stall
// cmd      | out | cmd_out_t  | cmd_valid / cmd_stall
// apb      | in  | model bit  | psel penable pwrite, pready high
// one word per cycle unless a valid cmd is stalled; the chain is 33 root cells
// + 64 divide cells + 1 fold cell + 2*min(CORDIC_ITERATIONS, 32) cordic cells,
// after 2 entry stages.
// the heading modulo runs in its own 64-step chain alongside the root and
// divide cells. a stall on a valid cmd freezes the whole chain; pose_stall
// follows it. reset clears the valid bits and the model register.
module pose_delta_velocity_command #(
	parameter int FRAC_BITS = pdvc_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_ITERATIONS = pdvc_pkg::CORDIC_ITER_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pose_valid,
	output logic pose_stall,
	input  pdvc_pkg::pose_in_t pose,
	output logic cmd_valid,
	input  logic cmd_stall,
	output pdvc_pkg::cmd_out_t cmd,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pdvc_pkg::*;

	localparam int NS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
	localparam int NC = 33 + 64 + 1 + 2 * NS;
	localparam int NMOD = 64;

	logic model_q;
	logic en;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {31'd0, model_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) model_q <= MODEL_DIFF;
		else if (psel && penable && pwrite && paddr == 2'd0) model_q <= pwdata[0];
	end

	assign en = !(cmd_valid && cmd_stall);
	assign pose_stall = !en;

	// entry stage
	logic signed [32:0] dx, dy, dth;
	logic [32:0] ax, ay, ath;
	logic [65:0] sum;
	always_comb begin
		dx = $signed({pose.next_x[31], pose.next_x}) - $signed({pose.cur_x[31], pose.cur_x});
		dy = $signed({pose.next_y[31], pose.next_y}) - $signed({pose.cur_y[31], pose.cur_y});
		dth = $signed({pose.next_heading[31], pose.next_heading})
			- $signed({pose.cur_heading[31], pose.cur_heading});
		ax = dx[32] ? 33'(-dx) : dx;
		ay = dy[32] ? 33'(-dy) : dy;
		ath = dth[32] ? 33'(-dth) : dth;
	end

	logic [32:0] ax_s1, ay_s1, ath_s1;
	logic dn_s1;
	logic [30:0] dt_s1;
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pose_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax; ay_s1 <= ay; ath_s1 <= ath;
			dn_s1 <= dth[32]; dt_s1 <= pose.time_step;
		end
	end
	// squares need their own register stage
	logic [65:0] sx_s2, sy_s2;
	logic [32:0] ath_s2; logic dn_s2; logic [30:0] dt_s2; logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= ax_s1 * ax_s1; sy_s2 <= ay_s1 * ay_s1;
			ath_s2 <= ath_s1; dn_s2 <= dn_s1; dt_s2 <= dt_s1;
		end
	end
	assign sum = sx_s2 + sy_s2;

	// chain of cells
	logic v_c [NC+1];
	logic [65:0] rad_c [NC+1]; logic [33:0] rem_c [NC+1]; logic [32:0] root_c [NC+1];
	logic [63:0] sn_c [NC+1]; logic [31:0] sr_c [NC+1]; logic [63:0] sq_c [NC+1];
	logic [63:0] an_c [NC+1]; logic [31:0] ar_c [NC+1]; logic [63:0] aq_c [NC+1];
	logic [34:0] mm_c [NC+1];
	logic signed [35:0] cx_c [NC+1], cy_c [NC+1], cz_c [NC+1];
	logic [30:0] dt_c [NC+1]; logic [3:0] fl_c [NC+1];

	// heading magnitude in q30 for the modulo chain
	logic [63:0] mq30;
	assign mq30 = 64'({31'd0, ath_s2} << (30 - FRAC_BITS));
	logic [34:0] mr [NMOD+1];
	logic [63:0] mv [NMOD+1];
	assign mr[0] = '0;
	assign mv[0] = mq30;
	for (genvar k = 0; k < NMOD; k++) begin : g_mod
		pdvc_modstep #(.BIT(NMOD - 1 - k)) u_m (
			.clk(clk), .en(en), .r_i(mr[k]), .m_i(mv[k]), .r_s1(mr[k+1]), .m_s1(mv[k+1]));
	end
	// modulo chain is 64 deep; it enters the cell chain at cell 97 with 33 cells of lag
	// so the chain is delayed by the gap between root+divide (97) and 64
	localparam int LAG = 33 + 64 - NMOD;
	logic [34:0] mdel [LAG];
	for (genvar k = 0; k < LAG; k++) begin : g_lag
		if (k == 0) begin : g_first
			always_ff @(posedge clk) if (en) mdel[0] <= mr[NMOD];
		end else begin : g_next
			always_ff @(posedge clk) if (en) mdel[k] <= mdel[k-1];
		end
	end

	assign v_c[0] = v_s2;
	assign rad_c[0] = sum; assign rem_c[0] = '0; assign root_c[0] = '0;
	assign sn_c[0] = '0; assign sr_c[0] = '0; assign sq_c[0] = '0;
	assign an_c[0] = 64'({31'd0, ath_s2} << FRAC_BITS);
	assign ar_c[0] = '0; assign aq_c[0] = '0;
	assign mm_c[0] = '0;
	assign cx_c[0] = '0; assign cy_c[0] = '0; assign cz_c[0] = '0;
	assign dt_c[0] = dt_s2; assign fl_c[0] = {dn_s2, 3'b000};

	for (genvar k = 0; k < NC; k++) begin : g_cell
		logic [63:0] sn_in;
		logic [34:0] mm_in;
		assign sn_in = (k == 33) ? 64'({31'd0, root_c[k]} << FRAC_BITS) : sn_c[k];
		assign mm_in = (k == 97) ? mdel[LAG-1] : mm_c[k];
		pdvc_cell #(.IDX(k), .NR(33), .ND(64), .NM(35), .NS(NS)) u_c (
			.clk(clk), .arst_n(arst_n), .en(en), .vin(v_c[k]),
			.rad_i(rad_c[k]), .rem_i(rem_c[k]), .root_i(root_c[k]),
			.sn_i(sn_in), .sr_i(sr_c[k]), .sq_i(sq_c[k]),
			.an_i(an_c[k]), .ar_i(ar_c[k]), .aq_i(aq_c[k]),
			.mm_i(mm_in), .cx_i(cx_c[k]), .cy_i(cy_c[k]), .cz_i(cz_c[k]),
			.dt_i(dt_c[k]), .fl_i((k == 33) ? {fl_c[k][3:1], root_c[k] == 33'd0} : fl_c[k]),
			.vout(v_c[k+1]),
			.rad_o(rad_c[k+1]), .rem_o(rem_c[k+1]), .root_o(root_c[k+1]),
			.sn_o(sn_c[k+1]), .sr_o(sr_c[k+1]), .sq_o(sq_c[k+1]),
			.an_o(an_c[k+1]), .ar_o(ar_c[k+1]), .aq_o(aq_c[k+1]),
			.mm_o(mm_c[k+1]), .cx_o(cx_c[k+1]), .cy_o(cy_c[k+1]), .cz_o(cz_c[k+1]),
			.dt_o(dt_c[k+1]), .fl_o(fl_c[k+1]));
	end

	// output stage
	cmd_out_t res;
	logic sat;
	logic signed [35:0] zr;
	always_comb begin
		sat = 1'b0;
		res = '0;
		zr = (cz_c[NC] + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (dt_c[NC] == 31'd0) begin
			res.status = ST_ZERO_DT;
		end else begin
			if (sq_c[NC] > 64'(SPEED_MAX)) begin
				res.linear_speed = SPEED_MAX; sat = 1'b1;
			end else res.linear_speed = sq_c[NC][30:0];
			if (model_q == MODEL_DIFF) begin
				if (fl_c[NC][3]) begin
					if (aq_c[NC] > 64'h80000000) begin
						res.turn_command = 32'sh80000000; sat = 1'b1;
					end else res.turn_command = 32'(-aq_c[NC]);
				end else begin
					if (aq_c[NC] > 64'h7fffffff) begin
						res.turn_command = 32'sh7fffffff; sat = 1'b1;
					end else res.turn_command = aq_c[NC][31:0];
				end
			end else begin
				res.turn_command = fl_c[NC][0] ? 32'sd0 : zr[31:0];
			end
			res.status = sat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmd_valid <= 1'b0;
		else if (en) cmd_valid <= v_c[NC];
	end
	always_ff @(posedge clk) begin
		if (en) cmd <= res;
	end

	logic unused;
	assign unused = ^{rad_c[NC], rem_c[NC], sn_c[NC], sr_c[NC], ar_c[NC], an_c[NC],
		mm_c[NC], cx_c[NC], cy_c[NC], fl_c[NC][2:1], mv[NMOD], root_c[NC], pwdata[31:1]};
endmodule

FILE: rtl/core/pdvc_cell.sv
// one pipeline cell, chosen by IDX: a root step, a divide step for speed and rate,
// the fold step, or a rotation or a vectoring cordic step
module pdvc_cell #(
	parameter int IDX = 0,
	parameter int NR = 33,
	parameter int ND = 64,
	parameter int NM = 35,
	parameter int NS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vin,
	input  logic [65:0] rad_i,  input logic [33:0] rem_i,  input logic [32:0] root_i,
	input  logic [63:0] sn_i,   input logic [31:0] sr_i,   input logic [63:0] sq_i,
	input  logic [63:0] an_i,   input logic [31:0] ar_i,   input logic [63:0] aq_i,
	input  logic [34:0] mm_i,
	input  logic signed [35:0] cx_i, input logic signed [35:0] cy_i,
	input  logic signed [35:0] cz_i,
	input  logic [30:0] dt_i,
	input  logic [3:0]  fl_i,
	output logic vout,
	output logic [65:0] rad_o,  output logic [33:0] rem_o,  output logic [32:0] root_o,
	output logic [63:0] sn_o,   output logic [31:0] sr_o,   output logic [63:0] sq_o,
	output logic [63:0] an_o,   output logic [31:0] ar_o,   output logic [63:0] aq_o,
	output logic [34:0] mm_o,
	output logic signed [35:0] cx_o, output logic signed [35:0] cy_o,
	output logic signed [35:0] cz_o,
	output logic [30:0] dt_o,
	output logic [3:0]  fl_o
);
	import pdvc_pkg::*;

	localparam int P_R = NR;
	localparam int P_D = P_R + ND;
	localparam int P_M = P_D + 1;
	localparam int P_S = P_M + NS;

	logic [65:0] rad_n; logic [33:0] rem_n; logic [32:0] root_n;
	logic [63:0] sn_n; logic [31:0] sr_n; logic [63:0] sq_n;
	logic [63:0] an_n; logic [31:0] ar_n; logic [63:0] aq_n;
	logic [34:0] mm_n;
	logic signed [35:0] cx_n, cy_n, cz_n;
	logic [34:0] trial;
	logic [34:0] rw;
	logic [32:0] dr;
	logic signed [35:0] xs, ys;
	logic [34:0] fa;
	logic signed [35:0] fs;

	always_comb begin
		rad_n = rad_i; rem_n = rem_i; root_n = root_i;
		sn_n = sn_i; sr_n = sr_i; sq_n = sq_i;
		an_n = an_i; ar_n = ar_i; aq_n = aq_i;
		mm_n = mm_i; cx_n = cx_i; cy_n = cy_i; cz_n = cz_i;
		trial = '0; rw = '0; dr = '0; xs = '0; ys = '0; fa = '0; fs = '0;
		if (IDX < P_R) begin
			// partial remainder needs one bit more than it keeps
			rw = {rem_i[32:0], rad_i[65:64]};
			rad_n = {rad_i[63:0], 2'b00};
			trial = {1'b0, root_i[31:0], 2'b01};
			root_n = {root_i[31:0], 1'b0};
			if (rw >= trial) begin
				rw = rw - trial;
				root_n[0] = 1'b1;
			end
			rem_n = rw[33:0];
		end else if (IDX < P_D) begin
			// restoring divide, one quotient bit per cell for both dividers
			dr = {sr_i, sn_i[63]};
			sn_n = {sn_i[62:0], 1'b0};
			sq_n = {sq_i[62:0], 1'b0};
			if (dr >= {2'b00, dt_i}) begin
				dr = dr - {2'b00, dt_i};
				sq_n[0] = 1'b1;
			end
			sr_n = dr[31:0];
			dr = {ar_i, an_i[63]};
			an_n = {an_i[62:0], 1'b0};
			aq_n = {aq_i[62:0], 1'b0};
			if (dr >= {2'b00, dt_i}) begin
				dr = dr - {2'b00, dt_i};
				aq_n[0] = 1'b1;
			end
			ar_n = dr[31:0];
		end else if (IDX < P_M) begin
			// fold the reduced angle into [-pi/2, pi/2], fl[3] = heading change negative
			fa = mm_i;
			if (fl_i[3] && fa != 35'd0) fa = Q30_TWO_PI - fa;
			fs = $signed({1'b0, fa});
			if (fa > Q30_PI) fs = fs - $signed({1'b0, Q30_TWO_PI});
			if (fs > $signed({1'b0, Q30_HALF_PI}))
				fs = $signed({1'b0, Q30_PI}) - fs;
			else if (fs < -$signed({1'b0, Q30_HALF_PI}))
				fs = -$signed({1'b0, Q30_PI}) - fs;
			cz_n = fs; cx_n = Q30_GAIN_INV; cy_n = '0;
		end else if (IDX < P_S) begin
			xs = cx_i >>> (IDX - P_M);
			ys = cy_i >>> (IDX - P_M);
			if (cz_i >= 0) begin
				cx_n = cx_i - ys; cy_n = cy_i + xs; cz_n = cz_i - atan_q30(IDX - P_M);
			end else begin
				cx_n = cx_i + ys; cy_n = cy_i - xs; cz_n = cz_i + atan_q30(IDX - P_M);
			end
			if (IDX == P_S - 1) begin
				cy_n = cy_n <<< 1; cx_n = Q30_ONE; cz_n = '0;
			end
		end else begin
			xs = cx_i >>> (IDX - P_S);
			ys = cy_i >>> (IDX - P_S);
			if (cy_i >= 0) begin
				cx_n = cx_i + ys; cy_n = cy_i - xs; cz_n = cz_i + atan_q30(IDX - P_S);
			end else begin
				cx_n = cx_i - ys; cy_n = cy_i + xs; cz_n = cz_i - atan_q30(IDX - P_S);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o <= rad_n; rem_o <= rem_n; root_o <= root_n;
			sn_o <= sn_n; sr_o <= sr_n; sq_o <= sq_n;
			an_o <= an_n; ar_o <= ar_n; aq_o <= aq_n;
			mm_o <= mm_n; cx_o <= cx_n; cy_o <= cy_n; cz_o <= cz_n;
			dt_o <= dt_i; fl_o <= fl_i;
		end
	end

	logic unused_nm;
	assign unused_nm = (NM == 0);
endmodule

FILE: rtl/core/pdvc_modstep.sv
// one bit of the remainder by 2*pi, msb first
module pdvc_modstep #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [34:0] r_i,
	input  logic [63:0] m_i,
	output logic [34:0] r_s1,
	output logic [63:0] m_s1
);
	import pdvc_pkg::*;
	logic [35:0] t;
	always_comb begin
		t = {r_i, m_i[BIT]};
		if (t >= {1'b0, Q30_TWO_PI}) t = t - {1'b0, Q30_TWO_PI};
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= t[34:0];
			m_s1 <= m_i;
		end
	end
endmodule

FILE: verif/pose_delta_velocity_command_tb.sv
module pose_delta_velocity_command_tb;
	import pdvc_pkg::*;

	localparam int LATENCY = 33 + 64 + 1 + 2 * CORDIC_ITER_DEF + 2;
	localparam int IDLE_LIMIT = 6000;
	localparam int LONG_HOLD = 500;
	localparam int RANDOM_ITEMS = 1320;
	localparam logic [1:0] REG_MODEL = 2'd0;
	localparam logic MODEL_ACKERMANN = 1'b1;

	class cmd_scoreboard;
		cmd_out_t expected_cmds[$];
		logic model;
		int errors;
		int checked;
		longint atan_tab[32];

		function new();
			model = MODEL_DIFF;
			errors = 0;
			checked = 0;
			atan_tab = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
				16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
				65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
				16, 8, 4, 2, 1, 0};
		endfunction

		function longint unsigned magnitude(longint v);
			return (v < 0) ? longint'(-v) : longint'(v);
		endfunction

		function longint unsigned dist_floor(longint unsigned ax, longint unsigned ay);
			logic [65:0] sum;
			logic [67:0] rem;
			logic [33:0] root;
			logic [67:0] trial;
			sum = {2'b0, ax * ax} + {2'b0, ay * ay};
			rem = '0;
			root = '0;
			for (int sh = 64; sh >= 0; sh -= 2) begin
				rem = (rem << 2) | sum[sh +: 2];
				trial = {root, 2'b01};
				root = root << 1;
				if (rem >= trial) begin
					rem = rem - trial;
					root[0] = 1'b1;
				end
			end
			return root;
		endfunction

		// rotation mode, starts at the inverse gain
		function longint sine_of(longint z);
			longint x, y, xs, ys;
			x = Q30_GAIN_INV;
			y = 0;
			for (int i = 0; i < CORDIC_ITER_DEF && i < 32; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_tab[i];
				end else begin
					x += ys; y -= xs; z += atan_tab[i];
				end
			end
			return y;
		endfunction

		// vectoring mode from x = 1.0
		function longint atan_of(longint y);
			longint x, z, xs, ys;
			x = Q30_ONE;
			z = 0;
			for (int i = 0; i < CORDIC_ITER_DEF && i < 32; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += atan_tab[i];
				end else begin
					x -= ys; y += xs; z -= atan_tab[i];
				end
			end
			return z;
		endfunction

		function longint steering(longint dth);
			longint unsigned m;
			longint a, two_pi, pi_q, half_pi, z;
			two_pi = longint'(Q30_TWO_PI);
			pi_q = longint'(Q30_PI);
			half_pi = longint'(Q30_HALF_PI);
			m = magnitude(dth) << (30 - FRAC_BITS_DEF);
			a = longint'(m % longint'(two_pi));
			if (dth < 0 && a != 0)
				a = two_pi - a;
			if (a > pi_q)
				a -= two_pi;
			if (a > half_pi)
				a = pi_q - a;
			else if (a < -half_pi)
				a = -pi_q - a;
			z = atan_of(2 * sine_of(a));
			return (z + (longint'(1) << (29 - FRAC_BITS_DEF))) >>> (30 - FRAC_BITS_DEF);
		endfunction

		function cmd_out_t velocity_command(pose_in_t p);
			cmd_out_t c;
			longint dx, dy, dth, turn;
			longint unsigned dt, span, speed, q;
			logic sat;
			dx = longint'(p.next_x) - longint'(p.cur_x);
			dy = longint'(p.next_y) - longint'(p.cur_y);
			dth = longint'(p.next_heading) - longint'(p.cur_heading);
			dt = p.time_step;
			sat = 1'b0;
			if (dt == 0) begin
				c.linear_speed = '0;
				c.turn_command = '0;
				c.status = ST_ZERO_DT;
				return c;
			end
			span = dist_floor(magnitude(dx), magnitude(dy));
			speed = (span << FRAC_BITS_DEF) / dt;
			if (speed > SPEED_MAX) begin
				speed = SPEED_MAX;
				sat = 1'b1;
			end
			if (model == MODEL_DIFF) begin
				q = (magnitude(dth) << FRAC_BITS_DEF) / dt;
				if (dth < 0) begin
					if (q > 64'h8000_0000) begin
						q = 64'h8000_0000;
						sat = 1'b1;
					end
					turn = -longint'(q);
				end else begin
					if (q > 64'h7fff_ffff) begin
						q = 64'h7fff_ffff;
						sat = 1'b1;
					end
					turn = longint'(q);
				end
			end else begin
				turn = (span == 0) ? 0 : steering(dth);
			end
			c.linear_speed = speed[30:0];
			c.turn_command = turn[31:0];
			c.status = sat ? ST_SAT : ST_OK;
			return c;
		endfunction

		function void note_pose(pose_in_t p);
			expected_cmds.push_back(velocity_command(p));
		endfunction

		function void check_cmd(cmd_out_t got);
			cmd_out_t exp_c;
			checked++;
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
				return;
			end
			exp_c = expected_cmds.pop_front();
			if (got.linear_speed !== exp_c.linear_speed) begin
				$display("%0t: linear_speed expected %0d actual %0d", $time,
					exp_c.linear_speed, got.linear_speed);
				errors++;
			end
			if (got.turn_command !== exp_c.turn_command) begin
				$display("%0t: turn_command expected %0d actual %0d", $time,
					exp_c.turn_command, got.turn_command);
				errors++;
			end
			if (got.status !== exp_c.status) begin
				$display("%0t: status expected %0d actual %0d", $time,
					exp_c.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic pose_valid, pose_stall, cmd_valid, cmd_stall;
	pose_in_t pose;
	cmd_out_t cmd;
	logic psel, penable, pwrite, pready;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;

	cmd_scoreboard sb;
	bit quiet;
	bit hold_req;
	int sent;
	int idle_cycles;
	int stall_left;

	pose_delta_velocity_command dut (
		.clk(clk), .arst_n(arst_n),
		.pose_valid(pose_valid), .pose_stall(pose_stall), .pose(pose),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// receiver: random stalls per word, plus one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sb.check_cmd(cmd);
			if (hold_req) begin
				hold_req <= 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				cmd_stall <= 1'b1;
				stall_left--;
			end else begin
				cmd_stall <= 1'b0;
				if (cmd_valid && !cmd_stall)
					stall_left = quiet ? 0 : $urandom_range(0, 16);
			end
		end
	end

	always @(posedge clk) begin
		if ((pose_valid && !pose_stall) || (cmd_valid && !cmd_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_pose(pose_in_t p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			pose_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose_valid <= 1'b1;
		pose <= p;
		do @(posedge clk); while (pose_stall);
		sb.note_pose(p);
		sent++;
	endtask

	task automatic drain();
		if (pose_valid)
			pose_valid <= 1'b0;
		while (sb.expected_cmds.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_model(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MODEL;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.model = value[0];
		@(posedge clk);
	endtask

	function automatic pose_in_t make_pose(int cx, int cy, int ch, int nx, int ny, int nh,
			logic [30:0] dt);
		pose_in_t p;
		p.cur_x = cx; p.cur_y = cy; p.cur_heading = ch;
		p.next_x = nx; p.next_y = ny; p.next_heading = nh;
		p.time_step = dt;
		return p;
	endfunction

	function automatic pose_in_t random_pose();
		pose_in_t p;
		int sel;
		p.cur_x = $urandom; p.cur_y = $urandom; p.cur_heading = $urandom;
		if ($urandom_range(0, 9) < 2) begin
			p.next_x = $urandom; p.next_y = $urandom; p.next_heading = $urandom;
		end else begin
			p.next_x = p.cur_x + int'($urandom_range(0, 1 << 21)) - (1 << 20);
			p.next_y = p.cur_y + int'($urandom_range(0, 1 << 21)) - (1 << 20);
			p.next_heading = p.cur_heading + int'($urandom_range(0, 1 << 20)) - (1 << 19);
		end
		sel = $urandom_range(0, 19);
		if (sel == 0)
			p.time_step = '0;
		else if (sel == 1)
			p.time_step = 31'($urandom);
		else if (sel == 2)
			p.time_step = 31'($urandom_range(1, 16));
		else
			p.time_step = 31'($urandom_range(1 << 10, 1 << 20));
		return p;
	endfunction

	task automatic directed_set();
		localparam int MX = 32'h7fff_ffff;
		localparam int MN = 32'h8000_0000;
		send_pose(make_pose(0, 0, 0, 0, 0, 0, 31'd0));
		send_pose(make_pose(1, 2, 3, 4, 5, 6, 31'h7fff_ffff));
		send_pose(make_pose(MN, MN, MN, MX, MX, MX, 31'd1));
		send_pose(make_pose(MX, MX, MX, MN, MN, MN, 31'd1));
		send_pose(make_pose(MN, 0, MX, MX, 0, MN, 31'h7fff_ffff));
		send_pose(make_pose(5, 7, 0, 5, 7, 32'h0003_243f, 31'h0001_0000));
		send_pose(make_pose(0, 0, 0, 32'h0001_0000, 0, 32'h0001_921f, 31'h0001_0000));
		send_pose(make_pose(0, 0, 0, 0, 32'h0003_0000, 32'hfffe_6de1, 31'h0000_8000));
		send_pose(make_pose(-1, -1, 0, 0, 0, -1, 31'd1));
		send_pose(make_pose(0, 0, 0, 3, 4, 32'h0006_487f, 31'h0001_0000));
		send_pose(make_pose(0, 0, 32'h0001_0000, 32'h0010_0000, 0, 0, 31'h4000_0000));
		send_pose(make_pose($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			31'd0));
	endtask

	task automatic random_phase(int count);
		repeat (count) send_pose(random_pose());
	endtask

	initial begin
		arst_n <= 1'b0;
		pose_valid <= 1'b0;
		pose <= '0;
		cmd_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= REG_MODEL;
		pwdata <= '0;
		sb = new();
		quiet = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		idle_cycles = 0;
		stall_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the model is differential drive
		directed_set();
		random_phase(RANDOM_ITEMS / 4);
		drain();

		write_model(32'h0000_0001);
		directed_set();
		quiet = 1'b1;
		hold_req = 1'b1;
		random_phase(RANDOM_ITEMS / 8);
		quiet = 1'b0;
		random_phase(RANDOM_ITEMS / 8);
		// sender waits for everything in flight before going on
		drain();
		random_phase(RANDOM_ITEMS / 8);
		drain();

		// only bit 0 of the written word counts
		write_model(32'hffff_fffe);
		random_phase(RANDOM_ITEMS / 4);
		drain();

		write_model(32'hffff_ffff);
		quiet = 1'b1;
		random_phase(RANDOM_ITEMS / 8);
		quiet = 1'b0;
		drain();

		$display("sent %0d pose words and checked %0d command words over both models,",
			sent, sb.checked);
		$display("with random stalls, a long receive hold-off and a full drain");
		if (sb.errors == 0 && sb.expected_cmds.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/pdvc_pkg.sv
rtl/core/pdvc_cell.sv
rtl/core/pdvc_modstep.sv
rtl/core/pose_delta_velocity_command.sv
verif/pose_delta_velocity_command_tb.sv
